### sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/mh2a_pkg.sv
// Types and constants of the MurmurHash2A stream hasher.
package mh2a_pkg;

    localparam logic [31:0] HASH_MUL      = 32'h5bd1e995;
    localparam int          MIX_SHIFT     = 24;
    localparam int          FINAL_SHIFT_A = 13;
    localparam int          FINAL_SHIFT_B = 15;
    localparam logic [2:0]  MAX_BYTES     = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_K1_WORD,
        OP_K1_TAIL,
        OP_K1_TOTAL,
        OP_K2,
        OP_HMIX,
        OP_AVAL,
        OP_EMIT
    } t_dp_op_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_HMIX,
        ST_AVAL,
        ST_EMIT
    } t_state_e;

    typedef enum logic [1:0] {
        PH_WORD,
        PH_TAIL,
        PH_TOTAL
    } t_phase_e;

    typedef struct packed {
        t_dp_op_e op;
    } t_dp_cmd;

    typedef struct packed {
        logic word_full;
        logic out_free;
    } t_dp_status;

endpackage

### sv/mh2a_dp.sv
// Datapath: byte gathering, shared multiplier, hash state and output register.
module mh2a_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mh2a_pkg::t_dp_cmd  i_cmd,
    input  logic [31:0]        i_data,
    input  logic [2:0]         i_count,
    output mh2a_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_out_hash
);
    import mh2a_pkg::*;

    logic [31:0] r_hash, r_word, r_total, r_k, r_out_hash;
    logic [23:0] r_tail;
    logic [1:0]  r_fill;
    logic        r_out_valid;

    logic [2:0]  count_sat;
    logic [31:0] data_masked;
    logic [55:0] combined;
    logic [2:0]  sum;
    logic [31:0] mul_a;
    logic [31:0] prod;

    always_comb begin
        count_sat = (i_count > MAX_BYTES) ? MAX_BYTES : i_count;
        for (int b = 0; b < 4; b++) begin
            data_masked[8*b +: 8] = (3'(b) < count_sat) ? i_data[8*b +: 8] : 8'h00;
        end
        combined = {32'h0, r_tail} | ({24'h0, data_masked} << {r_fill, 3'b000});
        sum      = {1'b0, r_fill} + count_sat;
    end

    // Operand select for the one multiplier.
    always_comb begin
        unique case (i_cmd.op)
            OP_K1_WORD:  mul_a = r_word;
            OP_K1_TAIL:  mul_a = {8'h00, r_tail};
            OP_K1_TOTAL: mul_a = r_total;
            OP_K2:       mul_a = r_k ^ (r_k >> MIX_SHIFT);
            OP_HMIX:     mul_a = r_hash;
            OP_AVAL:     mul_a = r_hash ^ (r_hash >> FINAL_SHIFT_A);
            default:     mul_a = r_hash;
        endcase
        prod = mul_a * HASH_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_total <= r_total + 32'(count_sat);
                    r_fill  <= sum[1:0];
                    if (sum[2]) begin
                        r_tail <= combined[55:32];
                    end else begin
                        r_tail <= combined[23:0];
                    end
                end
                OP_HMIX: r_hash <= prod ^ r_k;
                OP_AVAL: r_hash <= prod;
                OP_EMIT: begin
                    r_hash  <= '0;
                    r_tail  <= '0;
                    r_fill  <= '0;
                    r_total <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_word <= combined[31:0];
        end
        if (i_cmd.op == OP_K1_WORD || i_cmd.op == OP_K1_TAIL ||
            i_cmd.op == OP_K1_TOTAL || i_cmd.op == OP_K2) begin
            r_k <= prod;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out_hash <= r_hash ^ (r_hash >> FINAL_SHIFT_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.word_full = sum[2];
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_hash         = r_out_hash;

endmodule

### sv/mh2a_ctrl.sv
// Controller: sequences the word mixes, finalization and result hand-off.
module mh2a_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  mh2a_pkg::t_dp_status i_status,
    output mh2a_pkg::t_dp_cmd    o_cmd
);
    import mh2a_pkg::*;

    t_state_e r_state, n_state;
    t_phase_e r_phase, n_phase;
    logic     r_last,  n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_WORD;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_last     = r_last;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_last   = i_in_last;
                    if (i_status.word_full) begin
                        n_phase = PH_WORD;
                        n_state = ST_K1;
                    end else if (i_in_last) begin
                        n_phase = PH_TAIL;
                        n_state = ST_K1;
                    end
                end
            end
            ST_K1: begin
                unique case (r_phase)
                    PH_WORD:  o_cmd.op = OP_K1_WORD;
                    PH_TAIL:  o_cmd.op = OP_K1_TAIL;
                    PH_TOTAL: o_cmd.op = OP_K1_TOTAL;
                    default:  o_cmd.op = OP_NONE;
                endcase
                n_state = ST_K2;
            end
            ST_K2: begin
                o_cmd.op = OP_K2;
                n_state  = ST_HMIX;
            end
            ST_HMIX: begin
                o_cmd.op = OP_HMIX;
                unique case (r_phase)
                    PH_WORD: begin
                        if (r_last) begin
                            n_phase = PH_TAIL;
                            n_state = ST_K1;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    PH_TAIL: begin
                        n_phase = PH_TOTAL;
                        n_state = ST_K1;
                    end
                    default: n_state = ST_AVAL;
                endcase
            end
            ST_AVAL: begin
                o_cmd.op = OP_AVAL;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_last   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### sv/murmur2a_hash32_stream.sv
// Top level of the streaming MurmurHash2A (32-bit, seed 0) hasher.
//
//  channel   direction  payload (low bit up)                     handshake
//  s_axis    in         tdata: data_bytes[31:0], byte_count[34:32] tvalid/tready
//                       tlast: last
//  m_axis    out        tdata: hash_value[31:0]                  tvalid/tready
//
// A request with no full word and no last is only gathered; one that completes a
// word is accepted and then makes three passes through the single 32x32
// multiplier. A last request adds two more mixes (tail word, byte count) and
// the avalanche, and finally writes the hash into the output register once
// that register is free.
// Reset clears the hash state and the output valid; no clearing pass is needed.
// The output register lets a new message stream in while a hash waits; the
// sequencer stalls only when a second hash is ready before the first is taken.
`include "assert_macros.svh"

module murmur2a_hash32_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // data_bytes[31:0], byte_count[34:32], zero pad
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // hash_value[31:0]
);
    import mh2a_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_accept;

    // Sequencer: at most one multiplier operation per state.
    mh2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Gather bytes, hold the running hash, drive the result register.
    mh2a_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data      (i_s_axis_tdata[31:0]),
        .i_count     (i_s_axis_tdata[34:32]),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_hash  (o_m_axis_tdata)
    );

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // An accepted request is always latched by the datapath.
    `ASSERT_IMPL(a_accept_loads, i_clk, i_rst_n, in_accept, cmd.op == OP_LOAD)
    // A result is written only when the output register is free.
    `ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, cmd.op == OP_EMIT, status.out_free)
    // A last request always starts finalization, so the input stalls next cycle.
    `ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, in_accept && i_s_axis_tlast, !o_s_axis_tready)

endmodule

### test/murmur_hash_checker.sv
// Checker for the MurmurHash2A stream hasher: predicts each hash and compares it.
`timescale 1ns / 100ps

module murmur_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,     // data_bytes[31:0], byte_count[34:32], zero pad
    input  logic        i_s_tlast,     // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,     // hash_value[31:0]
    output int          o_mismatches,
    output int          o_pending
);

    localparam logic [31:0] MUL_K   = 32'h5bd1e995;
    localparam int          SH_MIX  = 24;
    localparam int          SH_AV_A = 13;
    localparam int          SH_AV_B = 15;

    logic [31:0] hash_acc;
    logic [23:0] tail_bytes;
    logic [1:0]  tail_len;
    logic [31:0] msg_len;
    logic [31:0] hash_expected_q[$];
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic logic [31:0] mix_in(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        logic [31:0] hh;
        kk = k * MUL_K;
        kk = kk ^ (kk >> SH_MIX);
        kk = kk * MUL_K;
        hh = h * MUL_K;
        return hh ^ kk;
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h,
                                                 input logic [23:0] tail,
                                                 input logic [31:0] len);
        logic [31:0] f;
        f = mix_in(h, {8'h00, tail});
        f = mix_in(f, len);
        f = f ^ (f >> SH_AV_A);
        f = f * MUL_K;
        f = f ^ (f >> SH_AV_B);
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [2:0]  nbytes;
        logic [7:0]  b;
        logic [31:0] want;
        if (!i_rst_n) begin
            hash_acc   = '0;
            tail_bytes = '0;
            tail_len   = '0;
            msg_len    = '0;
            hash_expected_q.delete();
        end else begin
            // absorb one accepted request
            if (i_s_tvalid && i_s_tready) begin
                nbytes = i_s_tdata[34:32];
                if (nbytes > 3'd4) nbytes = 3'd4;
                msg_len = msg_len + 32'(nbytes);
                for (int i = 0; i < 4; i++) begin
                    if (i < nbytes) begin
                        b = i_s_tdata[8*i +: 8];
                        if (tail_len == 2'd3) begin
                            hash_acc   = mix_in(hash_acc, {b, tail_bytes});
                            tail_bytes = '0;
                            tail_len   = '0;
                        end else begin
                            tail_bytes[8*tail_len +: 8] = b;
                            tail_len = tail_len + 2'd1;
                        end
                    end
                end
                if (i_s_tlast) begin
                    hash_expected_q.push_back(finish_hash(hash_acc, tail_bytes, msg_len));
                    hash_acc   = '0;
                    tail_bytes = '0;
                    tail_len   = '0;
                    msg_len    = '0;
                end
            end
            // compare one accepted hash with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (hash_expected_q.size() == 0) begin
                    report_mismatch("unexpected hash", i_m_tdata, 32'h0);
                end else begin
                    want = hash_expected_q.pop_front();
                    if (i_m_tdata !== want) report_mismatch("hash_value", i_m_tdata, want);
                end
            end
        end
        o_pending <= hash_expected_q.size();
    end

endmodule

### test/tb.sv
// Testbench top for the MurmurHash2A stream hasher: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // data_bytes[31:0], byte_count[34:32], zero pad
    logic        i_s_axis_tlast = 1'b0; // last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // hash_value[31:0]

    int mismatches;
    int pending;
    int hashed_chunks = 0;   // requests that add bytes or finish a message
    bit calm = 1'b0;         // set near the end: no idling on either side

    murmur2a_hash32_stream dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    murmur_hash_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run well past the slowest legal pace (gaps, stalls, finalization).
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Hash receiver: drop tready in bursts; the burst rate
    // changes from stretch to stretch so some stretches run with no stalls.
    initial begin : receiver
        int stall_left;
        int stall_odds;
        stall_left = 0;
        stall_odds = 4;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) stall_odds = $urandom_range(0, 8);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
                stall_left = $urandom_range(0, 12);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted. Optionally idle first.
    task automatic push_chunk(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, nbytes, data};
        i_s_axis_tlast  <= last;
        // hold until the edge at which tready was high
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (nbytes != 3'd0 || last) hashed_chunks++;
    endtask

    // One random message. Most carry random content with an occasional oversized
    // count; the rest mix in zero-byte requests, oversized counts and lone empty messages.
    task automatic random_message();
        int          n;
        int          kind;
        logic [2:0]  nbytes;
        logic [31:0] data;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            push_chunk($urandom, 3'd0, 1'b1);
        end else begin
            n = (kind < 10) ? $urandom_range(20, 64) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                if (kind < 85) begin
                    if ($urandom_range(0, 19) == 0)
                        nbytes = 3'($urandom_range(5, 7));
                    else if ($urandom_range(0, 2) == 0)
                        nbytes = 3'($urandom_range(1, 4));
                    else
                        nbytes = 3'd4;
                end else begin
                    nbytes = 3'($urandom_range(0, 7));
                end
                case ($urandom_range(0, 15))
                    0:       data = 32'h0000_0000;
                    1:       data = 32'hffff_ffff;
                    default: data = $urandom;
                endcase
                push_chunk(data, nbytes, i == n - 1);
            end
        end
    endtask

    initial begin : stimulus
        // hold reset, then release it once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then a zero-byte request on an empty hasher
        push_chunk(32'h0000_0000, 3'd0, 1'b1);
        push_chunk(32'hffff_ffff, 3'd0, 1'b0);
        push_chunk(32'h0000_0000, 3'd0, 1'b1);
        // single bytes at both extremes; unused bytes carry junk
        push_chunk(32'hffff_ff00, 3'd1, 1'b1);
        push_chunk(32'h0000_00ff, 3'd1, 1'b1);
        // one exact word of ones, and a count that saturates to four
        push_chunk(32'hffff_ffff, 3'd4, 1'b1);
        push_chunk(32'h1234_5678, 3'd7, 1'b1);
        // oversized counts mid-message, a zero-byte pause, odd tail
        push_chunk(32'hdead_beef, 3'd5, 1'b0);
        push_chunk(32'h0bad_f00d, 3'd6, 1'b0);
        push_chunk(32'hffff_ffff, 3'd0, 1'b0);
        push_chunk(32'h00a5_5a3c, 3'd3, 1'b1);
        // two-byte pieces, then finish with a zero-byte last
        push_chunk(32'hffff_0102, 3'd2, 1'b0);
        push_chunk(32'h5555_0304, 3'd2, 1'b0);
        push_chunk(32'haaaa_0506, 3'd2, 1'b0);
        push_chunk(32'h0000_0000, 3'd0, 1'b1);
        // three bytes then one: the word completes and an empty tail is mixed
        push_chunk(32'hff80_4020, 3'd3, 1'b0);
        push_chunk(32'hffff_ff10, 3'd1, 1'b1);
        // byte-wise build of a word of ones, ended by a full word
        push_chunk(32'h0000_00ff, 3'd1, 1'b0);
        push_chunk(32'h0000_ffff, 3'd2, 1'b0);
        push_chunk(32'hffff_ffff, 3'd4, 1'b1);

        while (hashed_chunks < 1750) begin
            if (hashed_chunks > 1500) calm = 1'b1;
            random_message();
        end
        i_s_axis_tvalid <= 1'b0;

        // drain: wait for every predicted hash, then let the pipe settle
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/mh2a_pkg.sv
sv/mh2a_dp.sv
sv/mh2a_ctrl.sv
sv/murmur2a_hash32_stream.sv
test/murmur_hash_checker.sv
test/tb.sv
